FILE: sv/sag_pkg.sv
// ----------------------------------------------------------------------------
// sag_pkg
// shared widths, constants and the per-lane search word of the smoothed
// absolute value gradient
// ----------------------------------------------------------------------------
package sag_pkg;

    localparam int DW   = 16;                       // sample and result width
    localparam int F    = DW - 1;                   // fraction bits of the result
    localparam int BW   = $clog2(DW);               // bit index width of the search
    localparam int SQW  = 2 * DW;                   // width of one square
    localparam int SMW  = 32;                       // smooth register width
    localparam int DSW  = ((SQW + 1 > SMW) ? SQW + 1 : SMW) + 1;  // denominator width
    localparam int SW   = 2 * DW + 3 + DSW + 1;     // signed search arithmetic width
    localparam int KSH  = 2 * F + 2;                // scale of the right-hand side

    localparam logic REG_SMOOTH       = 1'b0;
    localparam logic REG_COMPLEX_MODE = 1'b1;

    // one lane of the rounding search: bound, result so far, t*t*d and t*d
    typedef struct packed {
        logic                 neg;
        logic [SW-1:0]        kq;
        logic [DW-1:0]        r;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] t;
    } lane_t;

endpackage

FILE: sv/smoothed_abs_gradient.sv
// ----------------------------------------------------------------------------
// smoothed_abs_gradient
// y = x / sqrt(|x|^2 + smooth) as a rounded, saturated Q1.15 fraction
// ----------------------------------------------------------------------------
// stages in order: squares, denominator, a search stage per result bit, output register
// throughput: one word per cycle while the output is not held; a search stage per result bit sets the depth
// the whole pipeline holds while the output word waits on m_tready
// reset (aresetn low, synchronous): pipeline empty, smooth 0, real mode
// ----------------------------------------------------------------------------
module smoothed_abs_gradient (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration writes
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [sag_pkg::SMW-1:0] cfg_wdata,
    // input words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*sag_pkg::DW-1:0] s_tdata,   // x_re, x_im
    // output words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*sag_pkg::DW-1:0] m_tdata,   // y_re, y_im
    output logic                    m_tuser     // zero_denominator
);
    import sag_pkg::*;

    // configuration registers
    logic [SMW-1:0] smooth_reg;
    logic           cmode_reg;

    // whole pipeline moves together unless the output word is stuck
    logic en;

    // stage 1: magnitudes squared
    logic             v1_reg;
    logic             neg_re1_reg, neg_im1_reg;
    logic [SQW-1:0]   sq_re1_reg, sq_im1_reg;
    logic signed [DW-1:0] x_re, x_im;
    logic [DW-1:0]    ax_re, ax_im;

    // stage 2: denominator and search start
    logic             v2_reg;
    logic             z2_reg;
    logic [DSW-1:0]   d2_reg;
    lane_t            re2_reg, im2_reg;
    logic [DSW-1:0]   d2_next;

    // search stages, one per result bit
    logic             v_pipe_reg [DW];
    logic             z_pipe_reg [DW];
    logic [DSW-1:0]   d_pipe_reg [DW];
    lane_t            re_pipe [DW];
    lane_t            im_pipe [DW];

    // output register
    logic             m_valid_reg;
    logic [DW-1:0]    y_re_reg, y_im_reg;
    logic             zero_reg;
    logic [DW-1:0]    y_re_next, y_im_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
            cmode_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SMOOTH:       smooth_reg <= cfg_wdata;
                REG_COMPLEX_MODE: cmode_reg  <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // stage 1: unpack, absolute values, one 16x16 square per part
    assign x_re  = signed'(s_tdata[DW-1:0]);
    assign x_im  = cmode_reg ? signed'(s_tdata[2*DW-1:DW]) : '0;
    assign ax_re = x_re[DW-1] ? DW'(-x_re) : DW'(x_re);
    assign ax_im = x_im[DW-1] ? DW'(-x_im) : DW'(x_im);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_re1_reg <= x_re[DW-1];
            neg_im1_reg <= x_im[DW-1];
            sq_re1_reg  <= SQW'(ax_re) * SQW'(ax_im - ax_im + ax_re);
            sq_im1_reg  <= SQW'(ax_im) * SQW'(ax_im);
        end
    end

    // stage 2: d = re^2 + im^2 + smooth, start every lane at r = 0, t = -1
    assign d2_next = DSW'(sq_re1_reg) + DSW'(sq_im1_reg) + DSW'(smooth_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg     <= d2_next;
            z2_reg     <= (d2_next == '0);
            re2_reg.neg <= neg_re1_reg;
            re2_reg.kq  <= SW'(sq_re1_reg) << KSH;
            re2_reg.r   <= '0;
            re2_reg.s   <= signed'(SW'(d2_next));
            re2_reg.t   <= -signed'(SW'(d2_next));
            im2_reg.neg <= neg_im1_reg;
            im2_reg.kq  <= SW'(sq_im1_reg) << KSH;
            im2_reg.r   <= '0;
            im2_reg.s   <= signed'(SW'(d2_next));
            im2_reg.t   <= -signed'(SW'(d2_next));
        end
    end

    // search: stage i decides result bit F - i, highest first
    for (genvar i = 0; i < DW; i++) begin : g_search
        logic [DSW-1:0] d_in;
        logic           v_in, z_in;
        lane_t          re_in, im_in;

        if (i == 0) begin : g_first
            assign d_in  = d2_reg;
            assign v_in  = v2_reg;
            assign z_in  = z2_reg;
            assign re_in = re2_reg;
            assign im_in = im2_reg;
        end else begin : g_next
            assign d_in  = d_pipe_reg[i-1];
            assign v_in  = v_pipe_reg[i-1];
            assign z_in  = z_pipe_reg[i-1];
            assign re_in = re_pipe[i-1];
            assign im_in = im_pipe[i-1];
        end

        sag_root_step u_step_re (
            .aclk     (aclk),
            .en       (en),
            .bit_idx  (BW'(F - i)),
            .d        (d_in),
            .lane_in  (re_in),
            .lane_out (re_pipe[i])
        );

        sag_root_step u_step_im (
            .aclk     (aclk),
            .en       (en),
            .bit_idx  (BW'(F - i)),
            .d        (d_in),
            .lane_in  (im_in),
            .lane_out (im_pipe[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_pipe_reg[i] <= 1'b0;
            end else if (en) begin
                v_pipe_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_pipe_reg[i] <= d_in;
                z_pipe_reg[i] <= z_in;
            end
        end
    end

    // final stage: sign, saturate a positive unit result, zero on empty denominator
    always_comb begin
        if (re_pipe[DW-1].neg) begin
            y_re_next = DW'(-re_pipe[DW-1].r);
        end else if (re_pipe[DW-1].r[DW-1]) begin
            y_re_next = {1'b0, {(DW-1){1'b1}}};
        end else begin
            y_re_next = re_pipe[DW-1].r;
        end
        if (im_pipe[DW-1].neg) begin
            y_im_next = DW'(-im_pipe[DW-1].r);
        end else if (im_pipe[DW-1].r[DW-1]) begin
            y_im_next = {1'b0, {(DW-1){1'b1}}};
        end else begin
            y_im_next = im_pipe[DW-1].r;
        end
        if (z_pipe_reg[DW-1]) begin
            y_re_next = '0;
            y_im_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_pipe_reg[DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_re_reg <= y_re_next;
            y_im_reg <= y_im_next;
            zero_reg <= z_pipe_reg[DW-1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {y_im_reg, y_re_reg};
    assign m_tuser  = zero_reg;

    // an empty denominator always goes out as a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("zero denominator word with non-zero data");

    // input side only stalls behind a waiting output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

    // real mode keeps the imaginary part out of the denominator
    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s_tvalid && !cmode_reg) |=> (sq_im1_reg == '0))
        else $error("imaginary square leaked in real mode");

endmodule

FILE: sv/sag_root_step.sv
// ----------------------------------------------------------------------------
// sag_root_step
// one registered step of the rounding search: tries one result bit
// ----------------------------------------------------------------------------
module sag_root_step (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [sag_pkg::BW-1:0]  bit_idx,
    input  logic [sag_pkg::DSW-1:0] d,
    input  sag_pkg::lane_t          lane_in,
    output sag_pkg::lane_t          lane_out
);
    import sag_pkg::*;

    logic [BW+1:0]        sh_t;
    logic [BW+1:0]        sh_s;
    logic [BW+1:0]        sh_d;
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] s_cand;
    logic signed [SW-1:0] t_cand;
    logic                 fits;
    lane_t                lane_next;
    lane_t                lane_reg;

    // t grows by 2^(k+1): s += t*2^(k+2) + d*2^(2k+2), t*d += d*2^(k+1)
    assign sh_d   = {2'b00, bit_idx} + (BW+2)'(1);
    assign sh_t   = {2'b00, bit_idx} + (BW+2)'(2);
    assign sh_s   = {1'b0, bit_idx, 1'b0} + (BW+2)'(2);
    assign dx     = signed'(SW'(d));
    assign s_cand = lane_in.s + (lane_in.t <<< sh_t) + (dx <<< sh_s);
    assign t_cand = lane_in.t + (dx <<< sh_d);
    assign fits   = (s_cand <= signed'(lane_in.kq));

    always_comb begin
        lane_next = lane_in;
        if (fits) begin
            lane_next.r = lane_in.r | (DW'(1) << bit_idx);
            lane_next.s = s_cand;
            lane_next.t = t_cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: dv/tb_smoothed_abs_gradient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_abs_gradient
// self-checking bench: random and directed samples through the block under a
// range of smooth and mode settings, each output word checked field by field
// against a bit-exact rounding search done in the bench
// ----------------------------------------------------------------------------
module tb_smoothed_abs_gradient;
    import sag_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] im;
        logic signed [DW-1:0] re;
    } sample_t;

    typedef struct {
        logic [DW-1:0] y_re;
        logic [DW-1:0] y_im;
        logic          zden;
    } grad_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = REG_SMOOTH;
    logic [SMW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [2*DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2*DW-1:0] m_tdata;
    logic m_tuser;

    smoothed_abs_gradient dut (.*);

    // bench copy of the registers
    logic [31:0] smooth_q = '0;
    logic        cmode_q = 1'b0;

    sample_t pending_q[$];      // samples waiting for the driver
    grad_t   grad_q[$];         // expected gradients, oldest first
    int      errors = 0;
    int      checked = 0;
    int      cycles = 0;
    bit      src_idle_on = 1'b1;
    bit      snk_idle_on = 1'b1;
    bit      s_taken = 1'b0;    // offered word taken at the last rising edge
    int      hold_off = 0;      // long receiver stall, cycles
    int      src_gap = 0;
    int      snk_gap = 0;

    initial forever #4 aclk = ~aclk;

    // round-half-up of ax * 2^F / sqrt(d), largest r in [0, 2^F]
    function automatic logic [DW:0] round_ratio(logic [DW-1:0] ax, logic [63:0] d);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [DW:0] lo, hi, mid;
        logic [63:0] t;
        rhs = ({64'd0, 64'(ax) * 64'(ax)}) << KSH;
        lo = '0;
        hi = (DW+1)'(1) << F;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 64'(2 * mid - 1);
            lhs = 128'(t * t) * 128'(d);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [DW-1:0] scaled_part(logic signed [DW-1:0] x, logic [63:0] d);
        logic [DW-1:0] ax;
        logic [DW:0] r;
        ax = x < 0 ? DW'(-x) : DW'(x);
        if (x == {1'b1, {(DW-1){1'b0}}}) ax = {1'b1, {(DW-1){1'b0}}};
        r = round_ratio(ax, d);
        if (x < 0) return DW'(-r);
        // unit magnitude saturates on the positive side
        if (r > (1 << F) - 1) return DW'((1 << F) - 1);
        return DW'(r);
    endfunction

    function automatic grad_t predict_gradient(sample_t s);
        grad_t g;
        logic signed [DW-1:0] xi;
        logic [63:0] ar, ai, d;
        xi = cmode_q ? s.im : '0;
        ar = s.re < 0 ? 64'(-64'(s.re)) : 64'(s.re);
        ai = xi < 0 ? 64'(-64'(xi)) : 64'(xi);
        d = ar * ar + ai * ai + 64'(smooth_q);
        if (d == 0) begin
            g.y_re = '0; g.y_im = '0; g.zden = 1'b1;
        end else begin
            g.y_re = scaled_part(s.re, d);
            g.y_im = cmode_q ? scaled_part(xi, d) : '0;
            g.zden = 1'b0;
        end
        return g;
    endfunction

    // driver: prediction is made when the word is accepted
    always @(posedge aclk) begin
        s_taken = s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            grad_q.push_back(predict_gradient(sample_t'(s_tdata)));
            void'(pending_q.pop_front());
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // decide next offer, only after the previous one was taken or none was up
            if (!s_tvalid || s_taken) begin
                if (src_gap > 0) src_gap--;
                if (src_idle_on && src_gap == 0 && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 17);
                // note: pop happened at posedge, head is next item
                if (pending_q.size() > 0 && src_gap == 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare against oldest expectation
    always @(posedge aclk) begin
        grad_t g;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            if (grad_q.size() == 0) begin
                $error("output word with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                g = grad_q.pop_front();
                checked++;
                if (m_tdata[DW-1:0] !== g.y_re) begin
                    $error("y_re expected %h got %h", g.y_re, m_tdata[DW-1:0]);
                    errors++;
                end
                if (m_tdata[2*DW-1:DW] !== g.y_im) begin
                    $error("y_im expected %h got %h", g.y_im, m_tdata[2*DW-1:DW]);
                    errors++;
                end
                if (m_tuser !== g.zden) begin
                    $error("zero_denominator expected %b got %b", g.zden, m_tuser);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls, with one long hold-off counted here
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else begin
            if (snk_gap > 0) snk_gap--;
            if (snk_idle_on && snk_gap == 0 && $urandom_range(0, 9) == 0)
                snk_gap = $urandom_range(1, 17);
            m_tready <= aresetn && snk_gap == 0;
        end
    end

    task automatic write_reg(logic idx, logic [SMW-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SMOOTH) smooth_q = val;
        else cmode_q = val[0];
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || grad_q.size() > 0) @(posedge aclk);
        repeat (DW + 8) @(posedge aclk);
    endtask

    task automatic push_sample(logic [DW-1:0] re, logic [DW-1:0] im);
        sample_t s;
        s.re = re;
        s.im = im;
        pending_q.push_back(s);
    endtask

    // a mix of full-range, small-magnitude, near-real and power-of-two samples
    task automatic random_block(int n);
        logic [DW-1:0] re, im;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: begin re = $urandom; im = $urandom; end
                1: begin re = $urandom_range(0, 64) - 32; im = $urandom_range(0, 64) - 32; end
                2: begin re = $urandom; im = $urandom_range(0, 2) - 1; end
                default: begin re = {$urandom_range(0,1) ? 1'b1 : 1'b0, 15'(1 << $urandom_range(0,14))};
                               im = $urandom; end
            endcase
            push_sample(re, im);
        end
    endtask

    initial begin
        logic [31:0] smooth_set[6];
        smooth_set = '{32'd0, 32'd1, 32'd1000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h4000_0000};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset settings, extremes, zero denominator, unit magnitude
        push_sample(16'h0000, 16'h1234);
        push_sample(16'h7FFF, 16'h0000);
        push_sample(16'h8000, 16'h7FFF);
        push_sample(16'h0001, 16'hFFFF);
        push_sample(16'hFFFF, 16'h8000);
        drain();
        write_reg(REG_COMPLEX_MODE, 32'hFFFF_FFFF);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h0003, 16'h0004);
        push_sample(16'h0000, 16'h7FFF);
        push_sample(16'hAAAA, 16'h5555);
        drain();
        write_reg(REG_SMOOTH, 32'hFFFF_FFFF);
        push_sample(16'h7FFF, 16'h7FFF);
        push_sample(16'h0001, 16'h8000);
        push_sample(16'h0000, 16'h0000);
        drain();

        // random phases across settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_SMOOTH, ($urandom_range(0, 3) == 0) ? $urandom
                                                                : smooth_set[ph % 6]);
            write_reg(REG_COMPLEX_MODE, $urandom_range(0, 1));
            if (ph == 3) begin
                hold_off = 300;
                @(negedge aclk);
            end
            if (ph >= 10) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            random_block(110);
            drain();    // sender pauses until every result is in
        end

        $display("checked %0d gradient words over 12 random phases and directed extremes",
                 checked);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
